[design/pip_pkg.sv]
// Shared types and constants for the point-in-polygon crossing-number test.
// No dependencies; every module of the block but pip_vertex_mem imports this package.
package pip_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    // Fixed field widths of the request and result.
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int VC_W  = 7;

    // Vertex count after reset.
    localparam logic [VC_W-1:0] VC_RESET = 7'd3;

    // Request command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREV,
        ST_EDGE,
        ST_MUL1,
        ST_MUL2,
        ST_CMP
    } state_t;

    // Controls from the sequencer to the edge datapath.
    typedef struct packed {
        logic latch_pt;
        logic load_prev;
        logic edge_step;
        logic mul_first;
        logic mul_second;
    } dp_ctrl_t;

    // Status from the edge datapath to the sequencer.
    typedef struct packed {
        logic cand;
        logic vert;
        logic le;
    } dp_stat_t;

endpackage

[design/pip_vertex_mem.sv]
// Vertex store: one write port and one registered read port, x and y in one word.
// Depends on nothing but its parameters.
module pip_vertex_mem #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/pip_edge_dp.sv]
// Edge datapath: holds the test point and the previous vertex, evaluates the
// edge conditions and runs the shared multiplier for the crossing compare.
// Depends on pip_pkg.
module pip_edge_dp
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  dp_ctrl_t              ctrl,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic [COORD_BITS-1:0] vtx_x,
    input  logic [COORD_BITS-1:0] vtx_y,
    output dp_stat_t              stat
);

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    logic signed [C-1:0] px_reg, py_reg, x1_reg, y1_reg;
    logic signed [C-1:0] x2, y2, ylo, yhi, xhi;
    logic signed [D-1:0] dpx, dpy, dy, dx;
    logic signed [D-1:0] op_a1_reg, op_b1_reg, op_a2_reg, op_b2_reg;
    logic signed [D-1:0] mul_a, mul_b;
    logic signed [P-1:0] mul_p;
    logic signed [P-1:0] prod1_reg, prod2_reg;

    assign x2 = vtx_x;
    assign y2 = vtx_y;

    // Edge bounds, and differences on sign-extended coordinates.
    always_comb
    begin
        ylo = (y1_reg < y2) ? y1_reg : y2;
        yhi = (y1_reg < y2) ? y2 : y1_reg;
        xhi = (x1_reg > x2) ? x1_reg : x2;
        dpx = {px_reg[C-1], px_reg} - {x1_reg[C-1], x1_reg};
        dpy = {py_reg[C-1], py_reg} - {y1_reg[C-1], y1_reg};
        dy  = {y2[C-1], y2} - {y1_reg[C-1], y1_reg};
        dx  = {x2[C-1], x2} - {x1_reg[C-1], x1_reg};
    end

    // The edge is a candidate when it spans the point's y and reaches its x.
    always_comb
    begin
        stat.cand = (y1_reg != y2) && (py_reg > ylo) && (py_reg <= yhi) && (px_reg <= xhi);
        stat.vert = (x1_reg == x2);
        stat.le   = (prod1_reg <= prod2_reg);
    end

    // Point capture and previous-vertex tracking.
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_pt)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (ctrl.load_prev || ctrl.edge_step)
        begin
            x1_reg <= x2;
            y1_reg <= y2;
        end
    end

    // Operands of the crossing compare, normalized so the y span is positive.
    always_ff @(posedge clk)
    begin
        if (ctrl.edge_step)
        begin
            op_a1_reg <= dpx;
            op_b2_reg <= dx;
            if (dy < 0)
            begin
                op_b1_reg <= -dy;
                op_a2_reg <= -dpy;
            end
            else
            begin
                op_b1_reg <= dy;
                op_a2_reg <= dpy;
            end
        end
    end

    // Shared multiplier, one product per cycle.
    always_comb
    begin
        if (ctrl.mul_second)
        begin
            mul_a = op_a2_reg;
            mul_b = op_b2_reg;
        end
        else
        begin
            mul_a = op_a1_reg;
            mul_b = op_b1_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // Product registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_first)
        begin
            prod1_reg <= mul_p;
        end
        if (ctrl.mul_second)
        begin
            prod2_reg <= mul_p;
        end
    end

endmodule

[design/pip_ctrl.sv]
// Sequencer: walks the edges of the polygon, steers the shared multiplier,
// counts crossings and strobes the result. Depends on pip_pkg.
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            command,
    input  logic [VC_W-1:0] vertex_count,
    input  dp_stat_t        stat,
    output dp_ctrl_t        ctrl,
    output logic [AW-1:0]   rd_addr,
    output logic            busy,
    output logic            done,
    output logic            inside_res,
    output logic [CNT_W-1:0] crossings
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    state_t           state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] crossings_reg;
    logic             inside_reg;
    logic [NW-1:0]    n_eff;
    logic [AW-1:0]    last_idx;
    logic             is_last, test_req;

    // Vertex count saturated to capacity.
    always_comb
    begin
        if (int'(vertex_count) > MAX_VERTICES)
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vertex_count);
        end
        last_idx = AW'(n_eff - 1'b1);
        is_last  = (idx_reg == last_idx);
        test_req = start && (state_reg == ST_IDLE) && (command == CMD_TEST);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (test_req && (n_eff != '0))
                begin
                    state_next = ST_PREV;
                end
            end
            ST_PREV:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (stat.cand && !stat.vert)
                begin
                    state_next = ST_MUL1;
                end
                else if (is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = is_last ? ST_IDLE : ST_EDGE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs, read address, counters.
    always_comb
    begin
        ctrl       = '0;
        rd_addr    = idx_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr       = last_idx;
                ctrl.latch_pt = test_req;
                count_next    = test_req ? '0 : count_reg;
                done_next     = test_req && (n_eff == '0);
            end
            ST_PREV:
            begin
                ctrl.load_prev = 1'b1;
                idx_next       = '0;
                rd_addr        = '0;
            end
            ST_EDGE:
            begin
                ctrl.edge_step = 1'b1;
                if (!(stat.cand && !stat.vert))
                begin
                    count_next = count_reg + CNT_W'(stat.cand);
                    done_next  = is_last;
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                end
            end
            ST_MUL1:
            begin
                ctrl.mul_first = 1'b1;
            end
            ST_MUL2:
            begin
                ctrl.mul_second = 1'b1;
            end
            ST_CMP:
            begin
                count_next = count_reg + CNT_W'(stat.le);
                done_next  = is_last;
                idx_next   = idx_reg + 1'b1;
                rd_addr    = idx_reg + 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Walk index, count and result registers.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        if (done_next)
        begin
            crossings_reg <= count_next;
            inside_reg    <= count_next[0];
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign crossings  = crossings_reg;
    assign inside_res = inside_reg;

    // The result strobe only appears once the walk has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while walking edges");

    // The inside flag always matches the parity of the reported count.
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (inside_res == crossings[0]))
        else $error("inside flag disagrees with crossing parity");

    // A multiplying edge takes both products before the compare.
    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL1) |=> (state_reg == ST_MUL2) ##1 (state_reg == ST_CMP))
        else $error("multiply sequence broken");

    // The previous-vertex load only follows an accepted test.
    a_prev_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREV) |-> ($past(state_reg) == ST_IDLE && $past(start)))
        else $error("walk started without a test request");

endmodule

[design/point_in_polygon_test_top.sv]
// Point-in-polygon crossing-number test. A write request never raises busy. A test
// keeps busy high for a setup state (ST_PREV) and then, per edge, ST_EDGE alone for an
// edge that needs no crossing compare, or ST_EDGE, ST_MUL1, ST_MUL2 and ST_CMP for one
// that does (the one shared multiplier forms two products in turn). The result strobe
// comes in the cycle that busy drops, or, with no edges, in the cycle after the test is
// accepted; the receiver cannot stall. Reset clears the sequencer, sets the vertex count to 3.
module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [IDX_W-1:0]      index,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic                  cfg_we,
    input  logic [VC_W-1:0]       cfg_wdata,
    output logic                  done,
    output logic                  inside_res,
    output logic [CNT_W-1:0]      crossings
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = 2 * COORD_BITS;

    logic [VC_W-1:0] vertex_count_reg;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [DW-1:0]   rd_data;
    dp_ctrl_t        ctrl;
    dp_stat_t        stat;

    // Vertex count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_RESET;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // Vertex writes land only in slots that exist.
    assign wr_en = start && !busy && (command == CMD_WRITE) && (int'(index) < MAX_VERTICES);

    pip_vertex_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(index)),
        .wdata ({coord_x, coord_y}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pip_edge_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk     (clk),
        .ctrl    (ctrl),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .vtx_x   (rd_data[DW-1:COORD_BITS]),
        .vtx_y   (rd_data[COORD_BITS-1:0]),
        .stat    (stat)
    );

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .vertex_count (vertex_count_reg),
        .stat         (stat),
        .ctrl         (ctrl),
        .rd_addr      (rd_addr),
        .busy         (busy),
        .done         (done),
        .inside_res   (inside_res),
        .crossings    (crossings)
    );

endmodule

[verif/pip_checker.sv]
// Checker for the point-in-polygon test block: watches the request, configuration
// and result channels, predicts each test result and compares it field by field.
// Depends on pip_pkg for widths and command codes.
module pip_checker
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  command,
    input  logic [IDX_W-1:0]      index,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic                  cfg_we,
    input  logic [VC_W-1:0]       cfg_wdata,
    input  logic                  done,
    input  logic                  inside_res,
    input  logic [CNT_W-1:0]      crossings,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             in_poly;
        logic [CNT_W-1:0] crossings;
    } verdict_t;

    // Shadow copy of the polygon and the vertex count register.
    logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
    logic [VC_W-1:0]              vertex_count;

    // Verdicts of accepted tests, oldest first.
    verdict_t verdict_q [$];

    // Count the edges crossed by the ray from (px, py) toward +x. The crossing
    // abscissa is compared by cross-multiplication, so no division is needed.
    function automatic int count_crossings(input longint px, input longint py);
        int     n;
        int     prev;
        int     i;
        int     cnt;
        longint x1, y1, x2, y2, ylo, yhi, xhi, a, d, dx;
        n    = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        prev = (n > 0) ? n - 1 : 0;
        cnt  = 0;
        for (i = 0; i < n; i++)
        begin
            x1  = vx_mem[prev];
            y1  = vy_mem[prev];
            x2  = vx_mem[i];
            y2  = vy_mem[i];
            ylo = (y1 < y2) ? y1 : y2;
            yhi = (y1 < y2) ? y2 : y1;
            xhi = (x1 > x2) ? x1 : x2;
            if (y1 != y2 && py > ylo && py <= yhi && px <= xhi)
            begin
                if (x1 == x2)
                begin
                    cnt++;
                end
                else
                begin
                    a  = py - y1;
                    d  = y2 - y1;
                    dx = x2 - x1;
                    if (d < 0)
                    begin
                        a = -a;
                        d = -d;
                    end
                    if ((px - x1) * d <= a * dx)
                        cnt++;
                end
            end
            prev = i;
        end
        return cnt;
    endfunction

    // Track configuration and vertex writes, predict tests and check results.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        verdict_t want;
        int       cnt;
        if (!rst_n)
        begin
            vertex_count = VC_RESET;
            verdict_q.delete();
        end
        else
        begin
            if (cfg_we)
                vertex_count = cfg_wdata;
            if (start && !busy)
            begin
                if (command == CMD_WRITE)
                begin
                    if (index < MAX_VERTICES)
                    begin
                        vx_mem[index] = coord_x;
                        vy_mem[index] = coord_y;
                    end
                end
                else
                begin
                    cnt            = count_crossings($signed(coord_x), $signed(coord_y));
                    want.in_poly   = cnt[0];
                    want.crossings = cnt[CNT_W-1:0];
                    verdict_q      = {verdict_q, want};
                end
            end
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result with no test pending: inside_res=%0d crossings=%0d",
                           inside_res, crossings);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want.in_poly)
                    begin
                        $error("inside_res mismatch: expected %0d, actual %0d",
                               want.in_poly, inside_res);
                        fail_count++;
                    end
                    if (crossings !== want.crossings)
                    begin
                        $error("crossings mismatch: expected %0d, actual %0d",
                               want.crossings, crossings);
                        fail_count++;
                    end
                end
            end
        end
        pending <= verdict_q.size();
    end

endmodule

[verif/tb_point_in_polygon_test_top.sv]
// Testbench top for point_in_polygon_test_top: drives vertex writes, point tests
// and vertex count settings, and gives the verdict from the checker's failure count.
// Depends on pip_pkg, point_in_polygon_test_top and pip_checker.
module tb_point_in_polygon_test_top;
    import pip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_BITS_DEF;
    localparam int SLOTS       = MAX_VERTICES_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 3000000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             command   = CMD_WRITE;
    logic [IDX_W-1:0] index     = '0;
    logic [CW-1:0]    coord_x   = '0;
    logic [CW-1:0]    coord_y   = '0;
    logic             cfg_we    = 1'b0;
    logic [VC_W-1:0]  cfg_wdata = '0;
    logic             busy;
    logic             done;
    logic             inside_res;
    logic [CNT_W-1:0] crossings;
    int               fail_count;
    int               pending;

    // Stimulus bookkeeping: which slots hold a vertex and what was written there.
    bit               slot_written [SLOTS];
    logic [CW-1:0]    slot_x [SLOTS];
    logic [CW-1:0]    slot_y [SLOTS];
    int               idle_pct    = 26;
    int               items       = 0;
    int               cycle_count = 0;

    point_in_polygon_test_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .index      (index),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .inside_res (inside_res),
        .crossings  (crossings)
    );

    pip_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .index      (index),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .inside_res (inside_res),
        .crossings  (crossings),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("point_in_polygon_test_top regression: fail");
        $finish;
    end

    // Present one request after a random idle gap and hold it until accepted.
    task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [CW-1:0] x, input logic [CW-1:0] y);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        index   <= idx;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items++;
    endtask

    task automatic write_vertex(input int slot, input logic [CW-1:0] x,
                                input logic [CW-1:0] y);
        send_request(CMD_WRITE, IDX_W'(slot), x, y);
        slot_written[slot] = 1'b1;
        slot_x[slot]       = x;
        slot_y[slot]       = y;
    endtask

    // The index of a test request is ignored, so it carries random bits.
    task automatic test_point(input logic [CW-1:0] x, input logic [CW-1:0] y);
        send_request(CMD_TEST, IDX_W'($urandom_range(0, SLOTS - 1)), x, y);
    endtask

    // Stop sending and wait until every test result is back and the block is idle.
    task automatic wait_quiet();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int v);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= VC_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Either any 16-bit value or a value within +/- span of the origin.
    function automatic logic [CW-1:0] rand_coord(input bit wide, input int span);
        if (wide)
            return CW'($urandom_range(0, 65535));
        return CW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    initial
    begin : stimulus
        int            n;
        int            used;
        int            k;
        int            j;
        int            c;
        int            slot;
        int            r;
        bit            wide;
        bit            fresh;
        logic [CW-1:0] px;
        logic [CW-1:0] py;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Triangle under the reset vertex count of three.
        write_vertex(0, CW'(-100), CW'(-100));
        write_vertex(1, CW'(100), CW'(-100));
        write_vertex(2, CW'(0), CW'(100));
        test_point(CW'(0), CW'(0));
        test_point(CW'(200), CW'(0));
        test_point(CW'(-100), CW'(-100));
        test_point(CW'(0), CW'(-100));
        test_point(CW'(0), CW'(100));
        test_point(CW'(-50), CW'(0));
        test_point(16'h8000, CW'(0));
        test_point(16'h7FFF, 16'h7FFF);
        test_point(16'h8000, 16'h8000);

        // Square spanning the whole coordinate range, with vertical edges.
        set_vertex_count(4);
        write_vertex(0, 16'h8000, 16'h8000);
        write_vertex(1, 16'h7FFF, 16'h8000);
        write_vertex(2, 16'h7FFF, 16'h7FFF);
        write_vertex(3, 16'h8000, 16'h7FFF);
        test_point(CW'(0), CW'(0));
        test_point(16'h7FFF, CW'(0));
        test_point(16'h8000, CW'(0));
        test_point(16'h8000, 16'h7FFF);

        // No edges at all, then a single vertex closing on itself.
        set_vertex_count(0);
        test_point(CW'(0), CW'(0));
        set_vertex_count(1);
        test_point(CW'(0), 16'h8000);

        // Random polygons, each followed by a burst of tests with some stray writes.
        while (items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                n = $urandom_range(0, 2);
            else if (r < 7)
                n = ($urandom_range(0, 1) != 0) ? SLOTS : $urandom_range(SLOTS + 1, 127);
            else if (r < 25)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(3, 8);
            used = (n > SLOTS) ? SLOTS : n;
            wide = ($urandom_range(0, 99) < 30);
            idle_pct = (items >= 700 && items < 900) ? 0 : 26;
            set_vertex_count(n);

            // Sometimes keep the stored polygon when every slot in use is written.
            fresh = 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                fresh = 1'b0;
                for (j = 0; j < used; j++)
                    if (!slot_written[j])
                        fresh = 1'b1;
            end
            if (fresh)
                for (j = 0; j < used; j++)
                    write_vertex(j, rand_coord(wide, 40), rand_coord(wide, 40));

            k = $urandom_range(4, 14);
            for (j = 0; j < k; j++)
            begin
                c = $urandom_range(0, 99);
                if (c < 8)
                begin
                    write_vertex($urandom_range(0, SLOTS - 1), rand_coord(1'b1, 0),
                                 rand_coord(1'b1, 0));
                end
                else if (c < 28 && used > 0)
                begin
                    // Points on or next to a vertex hit the boundary rules.
                    slot = $urandom_range(0, used - 1);
                    px   = slot_x[slot] + CW'($urandom_range(0, 2)) - CW'(1);
                    py   = slot_y[slot] + CW'($urandom_range(0, 2)) - CW'(1);
                    test_point(px, py);
                end
                else
                begin
                    test_point(rand_coord(wide, 48), rand_coord(wide, 48));
                end
            end
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("point_in_polygon_test_top regression: pass");
        else
            $display("point_in_polygon_test_top regression: fail");
        $finish;
    end

endmodule
